// ===== rtl/mdbl_pkg.sv =====
// Shared constants and types for the Curve25519 x-only doubling pipeline.
// No dependencies; imported by mdbl_modmul and the top level.
`default_nettype none
package mdbl_pkg;

  localparam int FE_W    = 255;
  localparam int MUL_LAT = 7;

  typedef logic [FE_W-1:0] fe_t;

  localparam logic [255:0] P256   = {1'b0, 255'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffed};
  localparam logic [255:0] P256M1 = {1'b0, 255'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffec};
  localparam logic [255:0] A_COEF = 256'd486662;

endpackage
`default_nettype wire

// ===== rtl/montgomery_x_only_point_double_unit.sv =====
// Top level of the Curve25519 x-only point doubling pipeline.
// Depends on mdbl_pkg and mdbl_modmul.
`default_nettype none
// Doubles a point on y^2 = x^3 + 486662x^2 + x over GF(2^255-19) from its
// affine x and returns projective X = (x^2-1)^2 and Z = 4x(x^2+486662x+1),
// both fully reduced. One transaction is accepted every cycle unless a result
// waits at the output; each passes an input register, two 7-stage modular
// multiplier levels, one operand-prep stage and two output stages. The whole
// pipeline holds while a result waits on out_tready; nothing is lost or repeated.
// Input bit 255 is ignored and x in [p, 2^255) is taken mod p. x = 0 gives
// Z = 0, x = 1 or p-1 gives X = 0, passed through without a flag.
module montgomery_x_only_point_double_unit
  import mdbl_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // x_in_limb0[63:0], x_in_limb1[127:64], x_in_limb2[191:128], x_in_limb3[254:192], pad
  input  wire logic [255:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // x_out_limb0..3 [254:0], z_out_limb0..3 [509:255], pad [511:510]
  output logic [511:0]      out_tdata
);

  logic en;

  // input stage
  fe_t          x0_r;
  logic [255:0] xa_r;
  logic         v0_r;

  // first multiplier level: x*x and x*(x+A)
  logic m1a_vld, m1b_vld;
  fe_t  xx, u;
  fe_t  xd_r [MUL_LAT];

  // prep stage
  fe_t  a_r, b_r, x2_r;
  logic v1_r;

  // second multiplier level: (x^2-1)^2 and x*(x^2+Ax+1)
  logic m2a_vld, m2b_vld;
  fe_t  xo, zr;

  // output stages
  logic [255:0] zf_r, zf_nxt;
  logic [256:0] z4;
  logic [2:0]   zh;
  logic [6:0]   zh19;
  fe_t          xo1_r, xout_r, zout_r;
  logic         v2_r, vout_r;

  // advance everything unless a result is stuck at the output
  assign en        = !vout_r || out_tready;
  assign in_tready = en;

  mdbl_modmul u_sq (
    .clk, .rst_n, .en, .in_vld(v0_r),
    .a({1'b0, x0_r}), .b({1'b0, x0_r}),
    .out_vld(m1a_vld), .res(xx)
  );

  mdbl_modmul u_xa (
    .clk, .rst_n, .en, .in_vld(v0_r),
    .a({1'b0, x0_r}), .b(xa_r),
    .out_vld(m1b_vld), .res(u)
  );

  mdbl_modmul u_xo (
    .clk, .rst_n, .en, .in_vld(v1_r),
    .a({1'b0, a_r}), .b({1'b0, a_r}),
    .out_vld(m2a_vld), .res(xo)
  );

  mdbl_modmul u_zo (
    .clk, .rst_n, .en, .in_vld(v1_r),
    .a({1'b0, x2_r}), .b({1'b0, b_r}),
    .out_vld(m2b_vld), .res(zr)
  );

  // 4*zr is below 2^257: fold the two top bits and subtract p once
  always_comb begin
    z4     = {zr, 2'b00};
    zh     = {1'b0, z4[256:255]};
    zh19   = (7'(zh) << 4) + (7'(zh) << 1) + 7'(zh);
    zf_nxt = 256'(z4[254:0]) + 256'(zh19);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      vout_r <= 1'b0;
    end else if (en) begin
      v0_r   <= in_tvalid;
      v1_r   <= m1a_vld;
      v2_r   <= m2a_vld;
      vout_r <= v2_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      x0_r  <= in_tdata[254:0];
      xa_r  <= {1'b0, in_tdata[254:0]} + A_COEF;
      xd_r[0] <= x0_r;
      for (int k = 1; k < MUL_LAT; k++) xd_r[k] <= xd_r[k-1];
      // x^2 - 1 mod p, wrapping zero to p-1
      a_r   <= (xx == '0) ? P256M1[254:0] : FE_W'({1'b0, xx} - 256'd1);
      b_r   <= FE_W'({1'b0, u} + 256'd1);
      x2_r  <= xd_r[MUL_LAT-1];
      zf_r  <= zf_nxt;
      xo1_r <= xo;
      xout_r <= xo1_r;
      zout_r <= (zf_r >= P256) ? FE_W'(zf_r - P256) : zf_r[254:0];
    end
  end

  assign out_tvalid = vout_r;
  assign out_tdata  = {2'b00, zout_r, xout_r};

`ifndef SYNTH
  a_x_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[254:0]} < P256))
    else $error("X result not reduced");
  a_z_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[509:255]} < P256))
    else $error("Z result not reduced");
  a_lvl1_lock: assert property (@(posedge clk) disable iff (!rst_n)
    m1a_vld == m1b_vld)
    else $error("first multiplier level out of step");
  a_lvl2_lock: assert property (@(posedge clk) disable iff (!rst_n)
    m2a_vld == m2b_vld)
    else $error("second multiplier level out of step");
`endif

endmodule
`default_nettype wire

// ===== rtl/mdbl_modmul.sv =====
// Pipelined multiplier mod 2^255-19: 8x8 32-bit partial products, column sums,
// folding of the high half and final reduction. Depends on mdbl_pkg.
`default_nettype none
module mdbl_modmul
  import mdbl_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         in_vld,
  input  wire logic [255:0] a,
  input  wire logic [255:0] b,
  output logic              out_vld,
  output fe_t               res
);

  logic [MUL_LAT-1:0] vld_r;
  logic [63:0]  pp_r  [8][8];
  logic [35:0]  col_r [16];
  logic [35:0]  col_nxt [16];
  logic [42:0]  f_r   [8];
  logic [42:0]  f_nxt [8];
  logic [266:0] s_r, s_nxt, lo_v, hi_v;
  logic [255:0] t_r, t_nxt, v_r, v_nxt;
  logic [16:0]  h, h19;
  fe_t          res_r, res_nxt;

  // column sums of the partial products, 32-bit digit weights
  always_comb begin
    for (int k = 0; k < 16; k++) col_nxt[k] = '0;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        col_nxt[i+j]   = col_nxt[i+j]   + 36'(pp_r[i][j][31:0]);
        col_nxt[i+j+1] = col_nxt[i+j+1] + 36'(pp_r[i][j][63:32]);
      end
    end
  end

  // fold the upper eight columns: 2^256 = 38 mod p
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      f_nxt[k] = 43'(col_r[k]) + (43'(col_r[k+8]) << 5) + (43'(col_r[k+8]) << 2)
               + (43'(col_r[k+8]) << 1);
    end
  end

  // resolve the digit carries with one wide add
  always_comb begin
    lo_v = '0;
    hi_v = '0;
    for (int k = 0; k < 8; k++) begin
      lo_v[32*k +: 32]     = f_r[k][31:0];
      hi_v[32*(k+1) +: 11] = f_r[k][42:32];
    end
    s_nxt = lo_v + hi_v;
  end

  // fold at bit 255 twice, then subtract p once if needed
  always_comb begin
    h       = 17'(s_r[266:255]);
    h19     = (h << 4) + (h << 1) + h;
    t_nxt   = 256'(s_r[254:0]) + 256'(h19);
    v_nxt   = 256'(t_r[254:0]) + (t_r[255] ? 256'd19 : 256'd0);
    res_nxt = (v_r >= P256) ? FE_W'(v_r - P256) : v_r[254:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[MUL_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        for (int j = 0; j < 8; j++) begin
          pp_r[i][j] <= 64'(a[32*i +: 32]) * 64'(b[32*j +: 32]);
        end
      end
      col_r <= col_nxt;
      f_r   <= f_nxt;
      s_r   <= s_nxt;
      t_r   <= t_nxt;
      v_r   <= v_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_vld = vld_r[MUL_LAT-1];
  assign res     = res_r;

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking bench for montgomery_x_only_point_double_unit (Curve25519 x-only doubling).
// Predicts X and Z with wide-integer modular arithmetic; depends on mdbl_pkg and the RTL.
`timescale 1ns / 1ps

class doubling_scoreboard;
  logic [509:0] pending_points[$];
  int unsigned error_count;

  function new();
    error_count = 0;
  endfunction

  // Reduce a value below 2^512 mod p = 2^255 - 19 (fold twice, then subtract).
  static function logic [254:0] fold_mod(logic [511:0] v);
    logic [511:0] acc;
    acc = 512'(v[254:0]) + 512'(v[511:255]) * 512'd19;
    acc = 512'(acc[254:0]) + 512'(acc[511:255]) * 512'd19;
    if (acc >= {256'd0, mdbl_pkg::P256}) acc = acc - {256'd0, mdbl_pkg::P256};
    if (acc >= {256'd0, mdbl_pkg::P256}) acc = acc - {256'd0, mdbl_pkg::P256};
    return acc[254:0];
  endfunction

  static function logic [254:0] mul_mod(logic [254:0] a, logic [254:0] b);
    logic [511:0] prod;
    prod = {257'd0, a} * {257'd0, b};
    return fold_mod(prod);
  endfunction

  // Compute {Z, X} for the doubled point from affine x.
  static function logic [509:0] double_point(logic [255:0] word);
    logic [254:0] x, xx, xm1, xo, inner, zo;
    x = fold_mod({257'd0, word[254:0]});
    xx = mul_mod(x, x);
    xm1 = fold_mod({257'd0, xx} + {256'd0, mdbl_pkg::P256M1});
    xo = mul_mod(xm1, xm1);
    inner = fold_mod({257'd0, xx} + {257'd0, mul_mod(x, 255'd486662)} + 512'd1);
    zo = fold_mod({257'd0, mul_mod(x, inner)} * 512'd4);
    return {zo, xo};
  endfunction

  function void note_input(logic [255:0] word);
    pending_points = {pending_points, double_point(word)};
  endfunction

  function void check_result(logic [511:0] word);
    logic [509:0] want;
    logic [63:0]  want_limb;
    logic [63:0]  got_limb;
    int           lo;
    if (pending_points.size() == 0) begin
      $error("unexpected result transaction %h", word);
      error_count++;
      return;
    end
    want = pending_points.pop_front();
    for (int k = 0; k < 8; k++) begin
      lo = (k < 4) ? 64 * k : 255 + 64 * (k - 4);
      want_limb = 64'(want >> lo);
      got_limb  = 64'(word >> lo);
      // top limb of each coordinate carries 63 bits
      if (k % 4 == 3) begin
        want_limb[63] = 1'b0;
        got_limb[63]  = 1'b0;
      end
      if (got_limb !== want_limb) begin
        $error("%s_out_limb%0d: expected %h actual %h", (k < 4) ? "x" : "z", k % 4,
               want_limb, got_limb);
        error_count++;
      end
    end
  endfunction
endclass

module testbench
  import mdbl_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;   // x limbs 0..3 [254:0], bit 255 ignored
  logic         out_tvalid;
  logic         out_tready;
  logic [511:0] out_tdata;  // X [254:0], Z [509:255], pad [511:510]

  doubling_scoreboard points = new();
  int send_idle_pct;
  int recv_stall_pct;
  int stall_cycles = 0;

  montgomery_x_only_point_double_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: check accepted results, then choose the next ready.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) points.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [255:0] rand_word();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Present one point; hold it until accepted, with random idle cycles first.
  task automatic send_point(logic [255:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    points.note_input(word);
  endtask

  task automatic random_phase(int count);
    logic [255:0] word;
    repeat (count) begin
      case ($urandom_range(9))
        0: word = {1'b0, P256[254:0]} + 256'($urandom_range(19))
                  + {1'($urandom_range(1)), 255'd0};
        1: word = 256'($urandom_range(3)) | {1'($urandom_range(1)), 255'd0};
        default: word = rand_word();
      endcase
      send_point(word);
    end
  endtask

  initial begin
    logic [255:0] directed[$];
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Zero, one, two, p-1, p, p+1, above p, all ones (bit 255 set), bit 255 alone and with one,
    // single-limb extremes, the curve constant, and alternating bit patterns.
    directed = '{256'd0, 256'd1, 256'd2, {1'b0, P256M1[254:0]}, {1'b0, P256[254:0]},
                 {1'b0, P256[254:0]} + 1, {1'b0, P256[254:0]} + 18, {256{1'b1}},
                 {1'b1, 255'd0}, {1'b1, 255'd1}, {192'd0, 64'hffffffffffffffff},
                 {128'd0, 64'hffffffffffffffff, 64'd0},
                 {64'd0, 64'hffffffffffffffff, 128'd0},
                 {1'b0, 63'h7fffffffffffffff, 192'd0}, 256'd486662,
                 {128'haaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa, 128'haaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa},
                 {128'h55555555555555555555555555555555, 128'h55555555555555555555555555555555}};
    foreach (directed[i]) send_point(directed[i]);

    send_idle_pct = 26; recv_stall_pct = 60;
    random_phase(310);
    // Hold off until the pipeline has drained completely.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (points.pending_points.size() != 0) @(posedge clk);

    send_idle_pct = 60; recv_stall_pct = 26;
    random_phase(310);
    send_idle_pct = 0; recv_stall_pct = 0;
    random_phase(310);
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (points.pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (points.error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== montgomery_x_only_point_double_unit.f =====
rtl/mdbl_pkg.sv
rtl/mdbl_modmul.sv
rtl/montgomery_x_only_point_double_unit.sv
dv/testbench.sv
